// File: rtl/core/ufbs_pkg.sv
// shared constants and types for the union-find-by-size engine
package ufbs_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned ELEM_W       = 10;
  localparam int unsigned CFG_W        = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  typedef struct packed {
    logic [IDX_W-1:0] parent;
    logic [CNT_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } store_req_t;

  typedef struct packed {
    logic   ready;
    entry_t rd_data;
  } store_rsp_t;

endpackage

// File: rtl/core/ufbs_store.sv
// parent/size store with a clearing sweep after reset
module ufbs_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ufbs_pkg::store_req_t  req_i,
  output ufbs_pkg::store_rsp_t  rsp_o
);

  ufbs_pkg::entry_t mem [ufbs_pkg::MAX_ELEMENTS];
  ufbs_pkg::entry_t rdata_q;
  logic [ufbs_pkg::IDX_W:0] clr_q;
  logic ready;

  assign ready = clr_q[ufbs_pkg::IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!ready) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // sweep writes identity links of size one, then normal writes take over
  always_ff @(posedge clk_i) begin
    if (!ready) begin
      mem[clr_q[ufbs_pkg::IDX_W-1:0]] <= '{parent: clr_q[ufbs_pkg::IDX_W-1:0],
                                          size: ufbs_pkg::CNT_W'(1)};
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rsp_o.ready   = ready;
  assign rsp_o.rd_data = rdata_q;

endmodule

// File: rtl/core/union_find_by_size_core.sv
// top level: disjoint-set engine, weighted quick-union by size
//
// Command channel: an item (first_element_i, second_element_i) is taken at a
// rising edge with start high and busy low. The result appears on the result
// ports for one cycle with done_o high; the receiver cannot stall it, so it
// must sample every done_o beat.
// Each element is walked to its root through a store with a registered read
// port: one read per link followed, plus one for the root. When the two
// elements already share a root the result is given after the walks; else
// a merge first writes the loser link and the winner size back. With 1024
// elements a tree of s entries is at most log2(s) deep, so one shared tree
// is at most 10 deep and two separate trees at most 18 deep together.
// An out-of-range item is answered from idle without a walk, with index_error_o set.
// The next item is taken in the cycle that shows done_o.
// After reset the store is swept to identity links of size one, one entry a
// cycle, and busy stays high until the sweep is done. The element count register
// (cfg_we_i, cfg_wdata_i) may be written at any time while idle; it resets to
// 1024 and does not clear the store.
module union_find_by_size_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ufbs_pkg::ELEM_W-1:0] first_element_i,
  input  logic [ufbs_pkg::ELEM_W-1:0] second_element_i,
  input  logic                        cfg_we_i,
  input  logic [ufbs_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                        done_o,
  output logic [ufbs_pkg::ELEM_W-1:0] root_first_o,
  output logic [ufbs_pkg::ELEM_W-1:0] root_second_o,
  output logic                        already_joined_o,
  output logic [ufbs_pkg::ELEM_W-1:0] joined_root_o,
  output logic [ufbs_pkg::CFG_W-1:0]  set_count_o,
  output logic                        index_error_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_LINK,
    ST_GROW
  } state_e;

  state_e state_q;

  ufbs_pkg::store_req_t req;
  ufbs_pkg::store_rsp_t rsp;

  logic [ufbs_pkg::CFG_W-1:0] elem_count_q;
  logic [ufbs_pkg::CFG_W-1:0] eff_count;
  logic [ufbs_pkg::CFG_W-1:0] merges_q;
  logic [ufbs_pkg::IDX_W-1:0] node_q, b_q, ra_q, winner_q, loser_q;
  logic [ufbs_pkg::CNT_W-1:0] size_a_q, loser_size_q, sum_q;
  logic                       accept, range_err, is_root;

  ufbs_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  function automatic logic [ufbs_pkg::CFG_W-1:0] sets_left(
    input logic [ufbs_pkg::CFG_W-1:0] n,
    input logic [ufbs_pkg::CFG_W-1:0] m
  );
    return (n > m) ? n - m : '0;
  endfunction

  assign eff_count = (elem_count_q > ufbs_pkg::CFG_W'(ufbs_pkg::MAX_ELEMENTS))
                   ? ufbs_pkg::CFG_W'(ufbs_pkg::MAX_ELEMENTS) : elem_count_q;

  assign busy      = (state_q != ST_IDLE) || !rsp.ready;
  assign accept    = start && !busy;
  assign range_err = (ufbs_pkg::CFG_W'(first_element_i) >= eff_count) ||
                     (ufbs_pkg::CFG_W'(second_element_i) >= eff_count);
  assign is_root   = (rsp.rd_data.parent == node_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= ufbs_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      elem_count_q <= cfg_wdata_i;
    end
  end

  // store port: reads follow the walk, writes happen in link and grow
  always_comb begin
    req         = '0;
    req.rd_addr = node_q;
    case (state_q)
      ST_IDLE: begin
        req.rd_en   = accept && !range_err;
        req.rd_addr = ufbs_pkg::IDX_W'(first_element_i);
      end
      ST_WALK_A: begin
        req.rd_en   = 1'b1;
        req.rd_addr = is_root ? b_q : rsp.rd_data.parent;
      end
      ST_WALK_B: begin
        req.rd_en   = !is_root;
        req.rd_addr = rsp.rd_data.parent;
      end
      ST_LINK: begin
        req.wr_en   = 1'b1;
        req.wr_addr = loser_q;
        req.wr_data = '{parent: winner_q, size: loser_size_q};
      end
      ST_GROW: begin
        req.wr_en   = 1'b1;
        req.wr_addr = winner_q;
        req.wr_data = '{parent: winner_q, size: sum_q};
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      merges_q         <= '0;
      done_o           <= 1'b0;
      node_q           <= '0;
      b_q              <= '0;
      ra_q             <= '0;
      winner_q         <= '0;
      loser_q          <= '0;
      size_a_q         <= '0;
      loser_size_q     <= '0;
      sum_q            <= '0;
      root_first_o     <= '0;
      root_second_o    <= '0;
      already_joined_o <= 1'b0;
      joined_root_o    <= '0;
      set_count_o      <= '0;
      index_error_o    <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (range_err) begin
              done_o           <= 1'b1;
              root_first_o     <= '0;
              root_second_o    <= '0;
              already_joined_o <= 1'b0;
              joined_root_o    <= '0;
              set_count_o      <= sets_left(eff_count, merges_q);
              index_error_o    <= 1'b1;
            end else begin
              node_q  <= ufbs_pkg::IDX_W'(first_element_i);
              b_q     <= ufbs_pkg::IDX_W'(second_element_i);
              state_q <= ST_WALK_A;
            end
          end
        end
        ST_WALK_A: begin
          if (is_root) begin
            ra_q     <= node_q;
            size_a_q <= rsp.rd_data.size;
            node_q   <= b_q;
            state_q  <= ST_WALK_B;
          end else begin
            node_q <= rsp.rd_data.parent;
          end
        end
        ST_WALK_B: begin
          if (!is_root) begin
            node_q <= rsp.rd_data.parent;
          end else if (node_q == ra_q) begin
            done_o           <= 1'b1;
            root_first_o     <= ufbs_pkg::ELEM_W'(ra_q);
            root_second_o    <= ufbs_pkg::ELEM_W'(node_q);
            already_joined_o <= 1'b1;
            joined_root_o    <= ufbs_pkg::ELEM_W'(ra_q);
            set_count_o      <= sets_left(eff_count, merges_q);
            index_error_o    <= 1'b0;
            state_q          <= ST_IDLE;
          end else begin
            // smaller tree goes under the larger, ties keep the first root
            if (size_a_q < rsp.rd_data.size) begin
              winner_q     <= node_q;
              loser_q      <= ra_q;
              loser_size_q <= size_a_q;
            end else begin
              winner_q     <= ra_q;
              loser_q      <= node_q;
              loser_size_q <= rsp.rd_data.size;
            end
            sum_q   <= size_a_q + rsp.rd_data.size;
            state_q <= ST_LINK;
          end
        end
        ST_LINK: begin
          state_q <= ST_GROW;
        end
        ST_GROW: begin
          merges_q         <= merges_q + 1'b1;
          done_o           <= 1'b1;
          root_first_o     <= ufbs_pkg::ELEM_W'(ra_q);
          root_second_o    <= ufbs_pkg::ELEM_W'(node_q);
          already_joined_o <= 1'b0;
          joined_root_o    <= ufbs_pkg::ELEM_W'(winner_q);
          set_count_o      <= sets_left(eff_count, merges_q + 1'b1);
          index_error_o    <= 1'b0;
          state_q          <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == ST_IDLE))
    else $error("result beat outside idle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && index_error_o) |->
      (root_first_o == '0 && root_second_o == '0 && joined_root_o == '0 &&
       !already_joined_o))
    else $error("error beat carries root data");

  a_joined_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && already_joined_o) |->
      (root_first_o == root_second_o && joined_root_o == root_first_o))
    else $error("joined beat with differing roots");

  a_merge_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !already_joined_o && !index_error_o) |->
      (root_first_o != root_second_o &&
       (joined_root_o == root_first_o || joined_root_o == root_second_o)))
    else $error("merge beat with bad joined root");

  a_merge_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GROW) |=> (merges_q == $past(merges_q) + 1'b1))
    else $error("merge counter did not advance");

endmodule

// File: tb/union_find_by_size_core_test.sv
// testbench for the union-find-by-size core: directed and random pair traffic checked beat by beat
`timescale 1ns / 1ps

module union_find_by_size_core_test;

  localparam int unsigned RUN_LIMIT   = 500000;
  localparam int unsigned DRAIN_WAIT  = 32;
  localparam int unsigned MAX_GAP     = 18;

  typedef struct packed {
    logic [ufbs_pkg::ELEM_W-1:0] root_a;
    logic [ufbs_pkg::ELEM_W-1:0] root_b;
    logic                        same_set;
    logic [ufbs_pkg::ELEM_W-1:0] root_ab;
    logic [ufbs_pkg::CFG_W-1:0]  sets_left;
    logic                        range_err;
  } union_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [ufbs_pkg::ELEM_W-1:0] first_element_i;
  logic [ufbs_pkg::ELEM_W-1:0] second_element_i;
  logic                        cfg_we_i;
  logic [ufbs_pkg::CFG_W-1:0]  cfg_wdata_i;
  logic                        done_o;
  logic [ufbs_pkg::ELEM_W-1:0] root_first_o;
  logic [ufbs_pkg::ELEM_W-1:0] root_second_o;
  logic                        already_joined_o;
  logic [ufbs_pkg::ELEM_W-1:0] joined_root_o;
  logic [ufbs_pkg::CFG_W-1:0]  set_count_o;
  logic                        index_error_o;

  // shadow forest and configuration
  int unsigned   link_of   [ufbs_pkg::MAX_ELEMENTS];
  int unsigned   weight_of [ufbs_pkg::MAX_ELEMENTS];
  int unsigned   merge_total;
  int unsigned   count_limit;
  union_result_t pending_unions[$];
  int unsigned   fail_count;
  int unsigned   cycle_count;

  union_find_by_size_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .first_element_i  (first_element_i),
    .second_element_i (second_element_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .root_first_o     (root_first_o),
    .root_second_o    (root_second_o),
    .already_joined_o (already_joined_o),
    .joined_root_o    (joined_root_o),
    .set_count_o      (set_count_o),
    .index_error_o    (index_error_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned find_root(input int unsigned node);
    int unsigned steps;
    steps = 0;
    while (steps < ufbs_pkg::MAX_ELEMENTS && link_of[node] != node) begin
      node = link_of[node];
      steps++;
    end
    return node;
  endfunction

  function automatic union_result_t predict_union(input int unsigned a, input int unsigned b);
    union_result_t r;
    int unsigned   lim;
    int unsigned   ra;
    int unsigned   rb;
    r   = '0;
    lim = (count_limit > ufbs_pkg::MAX_ELEMENTS) ? ufbs_pkg::MAX_ELEMENTS : count_limit;
    if (a >= lim || b >= lim) begin
      r.range_err = 1'b1;
    end else begin
      ra = find_root(a);
      rb = find_root(b);
      r.root_a   = ufbs_pkg::ELEM_W'(ra);
      r.root_b   = ufbs_pkg::ELEM_W'(rb);
      r.same_set = (ra == rb);
      r.root_ab  = ufbs_pkg::ELEM_W'(ra);
      if (ra != rb) begin
        // smaller tree goes under the larger, ties put the second root under the first
        if (weight_of[ra] < weight_of[rb]) begin
          link_of[ra]    = rb;
          weight_of[rb] += weight_of[ra];
          r.root_ab      = ufbs_pkg::ELEM_W'(rb);
        end else begin
          link_of[rb]    = ra;
          weight_of[ra] += weight_of[rb];
        end
        merge_total = (merge_total + 1) & 11'h7ff;
      end
    end
    r.sets_left = ufbs_pkg::CFG_W'((lim > merge_total) ? lim - merge_total : 0);
    return r;
  endfunction

  // every done beat must match the oldest outstanding pair
  always @(posedge clk_i) begin
    union_result_t want;
    if (rst_ni && done_o) begin
      if (pending_unions.size() == 0) begin
        $error("result beat with no pair outstanding");
        fail_count++;
      end else begin
        want = pending_unions.pop_front();
        if (root_first_o !== want.root_a) begin
          $error("root_first: expected %0d, actual %0d", want.root_a, root_first_o);
          fail_count++;
        end
        if (root_second_o !== want.root_b) begin
          $error("root_second: expected %0d, actual %0d", want.root_b, root_second_o);
          fail_count++;
        end
        if (already_joined_o !== want.same_set) begin
          $error("already_joined: expected %0d, actual %0d", want.same_set, already_joined_o);
          fail_count++;
        end
        if (joined_root_o !== want.root_ab) begin
          $error("joined_root: expected %0d, actual %0d", want.root_ab, joined_root_o);
          fail_count++;
        end
        if (set_count_o !== want.sets_left) begin
          $error("set_count: expected %0d, actual %0d", want.sets_left, set_count_o);
          fail_count++;
        end
        if (index_error_o !== want.range_err) begin
          $error("index_error: expected %0d, actual %0d", want.range_err, index_error_o);
          fail_count++;
        end
      end
    end
  end

  // start stays high across back-to-back beats; send_pair lowers it only ahead of a gap
  task automatic send_pair(input int unsigned a, input int unsigned b);
    int unsigned gap;
    gap = $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    first_element_i  <= ufbs_pkg::ELEM_W'(a);
    second_element_i <= ufbs_pkg::ELEM_W'(b);
    do @(posedge clk_i); while (busy);
    pending_unions.push_back(predict_union(a, b));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_unions.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_element_count(input int unsigned value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ufbs_pkg::CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_limit = value & 11'h7ff;
  endtask

  task automatic test_reset_finds();
    send_pair(0, 0);
    send_pair(1023, 1023);
    send_pair(512, 512);
  endtask

  task automatic test_merge_by_size();
    send_pair(5, 9);     // equal sizes
    send_pair(9, 5);     // already joined
    send_pair(7, 9);     // single under larger tree
    send_pair(20, 21);
    send_pair(20, 5);    // smaller root first
    send_pair(0, 1023);
    send_pair(1023, 682);
    send_pair(341, 1023);
  endtask

  task automatic test_index_range();
    write_element_count(16);
    send_pair(16, 0);
    send_pair(0, 16);
    send_pair(1023, 1023);
    send_pair(15, 15);
    send_pair(15, 14);
  endtask

  task automatic test_count_zero();
    write_element_count(0);
    send_pair(0, 0);
    send_pair(0, 1);
  endtask

  task automatic test_count_clamp();
    write_element_count(2047);
    send_pair(1023, 1022);
    send_pair(1022, 1023);
  endtask

  task automatic test_set_count_saturation();
    // more merges have happened than elements remain in use
    write_element_count(4);
    send_pair(0, 1);
    send_pair(2, 3);
    send_pair(1, 2);
    send_pair(3, 4);
  endtask

  task automatic test_random_unions(input int unsigned count, input int unsigned n_items);
    int unsigned lim;
    int unsigned a;
    int unsigned b;
    int unsigned pick;
    write_element_count(count);
    lim = (count_limit > ufbs_pkg::MAX_ELEMENTS) ? ufbs_pkg::MAX_ELEMENTS : count_limit;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (lim == 0 || pick < 8) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else begin
        a = $urandom_range(0, lim - 1);
        b = (pick < 14) ? a : $urandom_range(0, lim - 1);
      end
      send_pair(a, b);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    first_element_i  = '0;
    second_element_i = '0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    fail_count       = 0;
    cycle_count      = 0;
    merge_total      = 0;
    count_limit      = 1024;
    for (int unsigned i = 0; i < ufbs_pkg::MAX_ELEMENTS; i++) begin
      link_of[i]   = i;
      weight_of[i] = 1;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_finds();
    test_merge_by_size();
    test_index_range();
    test_count_zero();
    test_count_clamp();
    test_set_count_saturation();
    test_random_unions(64, 250);
    test_random_unions(1024, 450);
    test_random_unions(2047, 250);
    test_random_unions(200, 200);
    test_random_unions(8, 100);
    test_random_unions(1, 50);
    test_random_unions(0, 30);
    test_random_unions(1024, 70);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
